### src/wsp_pkg.sv
// Shared widths for the wheel speed controller datapath.
// Used by the serial multiplier, the serial divider and the top level.
package wsp_pkg;

  localparam int unsigned MUL_A_W = 48;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);
  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 26;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

endpackage

### src/wsp_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on wsp_pkg for operand widths.
module wsp_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wsp_pkg::MUL_A_W-1:0]   a_i,
  input  logic [wsp_pkg::MUL_B_W-1:0]   b_i,
  output logic                          busy_o,
  output logic [wsp_pkg::MUL_P_W-1:0]   prod_o
);

  logic [wsp_pkg::MUL_A_W-1:0]   a_q;
  logic [wsp_pkg::MUL_A_W-1:0]   hi_q;
  logic [wsp_pkg::MUL_B_W-1:0]   lo_q;
  logic [wsp_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic [wsp_pkg::MUL_A_W:0]     sum;

  assign sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      a_q    <= a_i;
      hi_q   <= '0;
      lo_q   <= b_i;
      cnt_q  <= wsp_pkg::MUL_CNT_W'(wsp_pkg::MUL_B_W - 1);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      hi_q <= sum[wsp_pkg::MUL_A_W:1];
      lo_q <= {sum[0], lo_q[wsp_pkg::MUL_B_W-1:1]};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/wsp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wsp_pkg for operand widths.
module wsp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wsp_pkg::DIV_N_W-1:0]   num_i,
  input  logic [wsp_pkg::DIV_D_W-1:0]   den_i,
  output logic                          busy_o,
  output logic [wsp_pkg::DIV_N_W-1:0]   quot_o
);

  logic [wsp_pkg::DIV_N_W-1:0]   n_q;
  logic [wsp_pkg::DIV_D_W-1:0]   rem_q;
  logic [wsp_pkg::DIV_D_W-1:0]   den_q;
  logic [wsp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic [wsp_pkg::DIV_D_W:0]     trial;
  logic [wsp_pkg::DIV_D_W:0]     diff;
  logic                          ge;

  assign trial  = {rem_q, n_q[wsp_pkg::DIV_N_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign quot_o = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      n_q    <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      cnt_q  <= wsp_pkg::DIV_CNT_W'(wsp_pkg::DIV_N_W - 1);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      n_q   <= {n_q[wsp_pkg::DIV_N_W-2:0], ge};
      rem_q <= ge ? diff[wsp_pkg::DIV_D_W-1:0] : trial[wsp_pkg::DIV_D_W-1:0];
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/wheel_speed_pid_controller.sv
// Wheel speed PID controller: sequencer over one serial multiplier and one serial divider.
// Set target, soft stop, hard stop and a zero-length tick go straight to the emit state.
// A full tick runs up to ten products on the shift-add multiplier and up to five quotients
// on the restoring divider, one after the other.
// One word is in work at a time; a new word is taken while the last result waits.
// Reset (rst_ni low, asynchronous) clears all state and loads the register defaults.
module wheel_speed_pid_controller #(
  parameter int unsigned PWM_BITS    = 10,
  parameter int unsigned ACCEL_LIMIT = 300,
  parameter int unsigned TOP_SPEED   = 150,
  parameter int unsigned HOLD_DUTY   = 300,
  parameter int unsigned STILL_SPEED = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // elapsed_ms[9:0], encoder_count[41:10], target_speed[58:42], stop_ms[74:59]
  input  logic [79:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty_fwd[9:0], duty_rev[19:10], drive_value[30:20], speed_now[47:31],
  // speed_goal[64:48], mode[66:65]
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned DRV_LIM =
      (((1 << PWM_BITS) - 1) > 1023) ? 1023 : ((1 << PWM_BITS) - 1);
  localparam int unsigned TOP_RPM   = TOP_SPEED * 256;
  localparam int unsigned STILL_RPM = STILL_SPEED * 256;
  localparam int unsigned ACC_STEP  = ACCEL_LIMIT * 256;

  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_FLOOR = 3'd3;
  localparam logic [2:0] REG_CEIL  = 3'd4;
  localparam logic [2:0] REG_CPR   = 3'd5;
  localparam logic [2:0] REG_DSTOP = 3'd6;
  localparam logic [2:0] REG_INV   = 3'd7;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_SOFT = 2'd2;
  localparam logic [1:0] CMD_HARD = 2'd3;

  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_SOFT   = 2'd1;
  localparam logic [1:0] MODE_HARD   = 2'd2;

  localparam logic signed [17:0] STILL_POS = 18'(STILL_RPM);
  localparam logic signed [17:0] STILL_NEG = -18'(STILL_RPM);
  localparam logic signed [11:0] LIM_POS   = 12'(DRV_LIM);
  localparam logic signed [11:0] LIM_NEG   = -12'(DRV_LIM);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEN, ST_NUM, ST_SPD, ST_STOP_MUL, ST_STOP_DIV, ST_ACC_MUL, ST_ACC_DIV,
    ST_RAMP, ST_EDT, ST_DMUL, ST_DDIV, ST_PMUL, ST_IMUL, ST_IMUL2, ST_CLMUL, ST_CLDIV,
    ST_FINAL, ST_EMIT
  } state_e;

  // configuration
  logic [23:0]        prop_q, integ_q, deriv_q;
  logic signed [10:0] floor_q, ceil_q;
  logic [15:0]        cpr_q, dstop_q;
  logic               inv_q;

  // controller state
  state_e             state_q;
  logic               issued_q;
  logic [9:0]         dt_q;
  logic [31:0]        cnt_in_q;
  logic [1:0]         mode_q;
  logic signed [16:0] goal_q, ramped_q, meas_q, start_q;
  logic signed [47:0] isum_q, cand_q, pterm_q;
  logic signed [17:0] perr_q, e_q;
  logic [31:0]        prev_cnt_q;
  logic [15:0]        len_q;
  logic [16:0]        se_q;
  logic signed [10:0] drive_q;
  logic [25:0]        den_q;
  logic [22:0]        maxd_q;
  logic signed [36:0] dterm_q;
  logic signed [49:0] o_q;
  logic [9:0]         cl_q;
  logic               m_valid_q;
  logic [71:0]        m_data_q;

  // arithmetic units
  logic                          mul_start, mul_busy, div_start, div_busy, op_done;
  logic [wsp_pkg::MUL_A_W-1:0]   mul_a;
  logic [wsp_pkg::MUL_B_W-1:0]   mul_b;
  logic [wsp_pkg::MUL_P_W-1:0]   prod;
  logic [wsp_pkg::DIV_N_W-1:0]   div_n, quot;
  logic [wsp_pkg::DIV_D_W-1:0]   div_d;

  // input word
  logic               s_acc;
  logic [1:0]         in_cmd;
  logic [9:0]         in_dt;
  logic [31:0]        in_cnt;
  logic signed [16:0] in_tgt, tgt_neg, tgt_goal;
  logic [15:0]        in_stop;

  // datapath
  logic [15:0]        cpr_eff;
  logic [31:0]        d_enc, d_mag;
  logic [16:0]        start_mag, meas_mag, g_mag, r_mag, qcap_neg;
  logic signed [16:0] meas_new, stop_goal, ramp_new;
  logic [17:0]        se_sum, e_mag;
  logic [16:0]        se_new;
  logic signed [23:0] delta, delta_c, maxd_s;
  logic               same_side, toward;
  logic signed [17:0] e_new;
  logic signed [18:0] diff;
  logic [18:0]        diff_mag;
  logic [27:0]        edt;
  logic signed [48:0] cand_sum, edt_s;
  logic signed [47:0] cand_sat;
  logic [47:0]        cand_mag, isum_mag;
  logic [35:0]        dm;
  logic signed [36:0] dterm_new;
  logic signed [47:0] term_new;
  logic signed [49:0] o_new, lo, hi, o_clamp, o_mag;
  logic               in_range, cl_skip;
  logic [15:0]        cl_base;
  logic signed [11:0] pwm0, pwm1, pwm2, cl_s;
  logic               still;
  logic signed [10:0] drive_neg;
  logic [9:0]         duty_fwd, duty_rev;

  function automatic logic [46:0] gain_cap(input logic [wsp_pkg::MUL_P_W-1:0] p);
    logic [63:0] sh;
    sh = p[71:8];
    gain_cap = (|sh[63:47] || (sh[46] && |sh[45:0])) ? {1'b1, 46'b0} : sh[46:0];
  endfunction

  wsp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  wsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = s_axis_tuser;
  assign in_dt         = s_axis_tdata[9:0];
  assign in_cnt        = s_axis_tdata[41:10];
  assign in_tgt        = s_axis_tdata[58:42];
  assign in_stop       = s_axis_tdata[74:59];
  assign tgt_neg       = (in_tgt == 17'sh10000) ? 17'sh0FFFF : -in_tgt;
  assign tgt_goal      = inv_q ? tgt_neg : in_tgt;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // speed measurement
  assign cpr_eff  = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign d_enc    = cnt_in_q - prev_cnt_q;
  assign d_mag    = d_enc[31] ? -d_enc : d_enc;
  assign qcap_neg = (|quot[63:17] || (quot[16] && |quot[15:0])) ? 17'h10000 : quot[16:0];
  assign meas_new = d_enc[31] ? -$signed(qcap_neg)
                  : ((|quot[63:16]) ? 17'sh0FFFF : $signed({1'b0, quot[15:0]}));
  assign meas_mag = meas_q[16] ? 17'(-meas_q) : meas_q;

  // soft stop
  assign start_mag = start_q[16] ? 17'(-start_q) : start_q;
  assign se_sum    = {1'b0, se_q} + 18'(dt_q);
  assign se_new    = se_sum[17] ? 17'h1FFFF : se_sum[16:0];
  assign stop_goal = start_q[16] ? start_q + $signed(quot[16:0])
                                 : start_q - $signed(quot[16:0]);

  // acceleration cap
  assign g_mag     = goal_q[16] ? 17'(-goal_q) : goal_q;
  assign r_mag     = ramped_q[16] ? 17'(-ramped_q) : ramped_q;
  assign same_side = (!goal_q[16] && !ramped_q[16])
                  || ((goal_q[16] || goal_q == '0) && (ramped_q[16] || ramped_q == '0));
  assign toward    = (g_mag < r_mag) && same_side;
  assign delta     = 24'(goal_q) - 24'(ramped_q);
  assign maxd_s    = $signed({1'b0, maxd_q});
  always_comb begin
    delta_c = delta;
    if (!toward) begin
      if (delta > maxd_s) begin
        delta_c = maxd_s;
      end else if (delta < -maxd_s) begin
        delta_c = -maxd_s;
      end
    end
  end
  assign ramp_new = 17'(24'(ramped_q) + delta_c);
  assign e_new    = 18'(ramp_new) - 18'(meas_q);

  // PID terms
  assign e_mag    = e_q[17] ? 18'(-e_q) : e_q;
  assign diff     = 19'(e_q) - 19'(perr_q);
  assign diff_mag = diff[18] ? 19'(-diff) : diff;
  assign edt      = prod[27:0];
  assign edt_s    = e_q[17] ? -$signed({21'b0, edt}) : $signed({21'b0, edt});
  assign cand_sum = 49'(isum_q) + edt_s;
  assign cand_sat = (cand_sum[48] != cand_sum[47])
                  ? (cand_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : cand_sum[47:0];
  assign cand_mag = cand_q[47] ? 48'(-cand_q) : cand_q;
  assign isum_mag = isum_q[47] ? 48'(-isum_q) : isum_q;
  assign dm        = quot[35:0];
  assign dterm_new = diff[18] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});

  always_comb begin
    logic sign;
    sign = (state_q == ST_PMUL) ? e_q[17]
         : ((state_q == ST_IMUL) ? cand_q[47] : isum_q[47]);
    term_new = sign ? -$signed({1'b0, gain_cap(prod)}) : $signed({1'b0, gain_cap(prod)});
  end

  assign o_new    = 50'(pterm_q) + 50'(term_new) + 50'(dterm_q);
  assign lo       = {{23{floor_q[10]}}, floor_q, 16'b0};
  assign hi       = {{23{ceil_q[10]}}, ceil_q, 16'b0};
  assign in_range = !(o_new < lo) && !(o_new > hi);

  // drive shaping
  assign cl_skip = meas_mag >= 17'(TOP_RPM);
  assign cl_base = 16'(17'(TOP_RPM) - meas_mag);
  assign o_clamp = (o_q < lo) ? lo : ((o_q > hi) ? hi : o_q);
  assign o_mag   = o_clamp[49] ? -o_clamp : o_clamp;
  assign pwm0    = o_clamp[49] ? -$signed({1'b0, o_mag[26:16]}) : $signed({1'b0, o_mag[26:16]});
  assign pwm1    = (pwm0 > LIM_POS) ? LIM_POS : ((pwm0 < LIM_NEG) ? LIM_NEG : pwm0);
  assign cl_s    = $signed({2'b0, cl_q});
  assign still   = (ramped_q == '0) && (meas_mag < 17'(STILL_RPM));
  always_comb begin
    pwm2 = pwm1;
    if (18'(meas_q) > STILL_POS && pwm1 < -cl_s) begin
      pwm2 = -cl_s;
    end else if (18'(meas_q) < STILL_NEG && pwm1 > cl_s) begin
      pwm2 = cl_s;
    end
    if (still) begin
      pwm2 = '0;
    end
  end

  assign drive_neg = -drive_q;
  assign duty_fwd  = drive_q[10] ? 10'd0 : drive_q[9:0];
  assign duty_rev  = drive_q[10] ? drive_neg[9:0] : 10'd0;

  // unit operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    unique case (state_q)
      ST_DEN:      begin mul_a = 48'(cpr_eff);   mul_b = 24'(dt_q);      end
      ST_NUM:      begin mul_a = 48'(d_mag);     mul_b = 24'd15360000;   end
      ST_STOP_MUL: begin mul_a = 48'(se_q);      mul_b = 24'(start_mag); end
      ST_ACC_MUL:  begin mul_a = 48'(dt_q);      mul_b = 24'(ACC_STEP);  end
      ST_EDT:      begin mul_a = 48'(e_mag);     mul_b = 24'(dt_q);      end
      ST_DMUL:     begin mul_a = 48'(diff_mag);  mul_b = deriv_q;        end
      ST_PMUL:     begin mul_a = 48'(e_mag);     mul_b = prop_q;         end
      ST_IMUL:     begin mul_a = cand_mag;       mul_b = integ_q;        end
      ST_IMUL2:    begin mul_a = isum_mag;       mul_b = integ_q;        end
      ST_CLMUL:    begin mul_a = 48'(cl_base);   mul_b = 24'(HOLD_DUTY); end
      default:     begin mul_a = '0;             mul_b = '0;             end
    endcase
    unique case (state_q)
      ST_DEN, ST_NUM, ST_STOP_MUL, ST_ACC_MUL, ST_EDT, ST_DMUL, ST_PMUL, ST_IMUL,
      ST_IMUL2:  mul_start = !issued_q;
      ST_CLMUL:  mul_start = !issued_q && !cl_skip;
      default:   mul_start = 1'b0;
    endcase
  end

  always_comb begin
    div_n     = prod[63:0];
    div_d     = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_SPD:      begin div_d = den_q;              div_start = !issued_q; end
      ST_STOP_DIV: begin div_d = 26'(len_q);         div_start = !issued_q; end
      ST_ACC_DIV:  begin div_d = 26'd1000;           div_start = !issued_q; end
      ST_DDIV:     begin div_d = 26'({dt_q, 8'd0});  div_start = !issued_q; end
      ST_CLDIV:    begin div_d = 26'(TOP_RPM);       div_start = !issued_q; end
      default:     begin div_d = '0;                 div_start = 1'b0;      end
    endcase
  end

  assign op_done = issued_q && !mul_busy && !div_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= 24'd65536;
      integ_q <= '0;
      deriv_q <= '0;
      floor_q <= -11'sd1023;
      ceil_q  <= 11'sd1023;
      cpr_q   <= 16'd1920;
      dstop_q <= 16'd500;
      inv_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROP:  prop_q  <= cfg_wdata_i;
        REG_INTEG: integ_q <= cfg_wdata_i;
        REG_DERIV: deriv_q <= cfg_wdata_i;
        REG_FLOOR: floor_q <= cfg_wdata_i[10:0];
        REG_CEIL:  ceil_q  <= cfg_wdata_i[10:0];
        REG_CPR:   cpr_q   <= cfg_wdata_i[15:0];
        REG_DSTOP: dstop_q <= cfg_wdata_i[15:0];
        REG_INV:   inv_q   <= cfg_wdata_i[0];
      endcase
    end
  end

  // sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issued_q   <= 1'b0;
      dt_q       <= '0;
      cnt_in_q   <= '0;
      mode_q     <= MODE_ACTIVE;
      goal_q     <= '0;
      ramped_q   <= '0;
      meas_q     <= '0;
      isum_q     <= '0;
      perr_q     <= '0;
      prev_cnt_q <= '0;
      start_q    <= '0;
      len_q      <= '0;
      se_q       <= '0;
      drive_q    <= '0;
      den_q      <= '0;
      maxd_q     <= '0;
      e_q        <= '0;
      cand_q     <= '0;
      dterm_q    <= '0;
      pterm_q    <= '0;
      o_q        <= '0;
      cl_q       <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != ST_EMIT) begin
        m_valid_q <= 1'b0;
      end
      if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            dt_q     <= in_dt;
            cnt_in_q <= in_cnt;
            state_q  <= ST_EMIT;
            unique case (in_cmd)
              CMD_SET: begin
                goal_q <= tgt_goal;
                if (mode_q == MODE_HARD) begin
                  mode_q <= MODE_ACTIVE;
                end
              end
              CMD_SOFT: begin
                if (mode_q == MODE_ACTIVE) begin
                  isum_q  <= '0;
                  perr_q  <= '0;
                  mode_q  <= MODE_SOFT;
                  se_q    <= '0;
                  len_q   <= (in_stop != '0) ? in_stop : dstop_q;
                  start_q <= goal_q;
                end
              end
              CMD_HARD: begin
                mode_q   <= MODE_HARD;
                goal_q   <= '0;
                ramped_q <= '0;
                isum_q   <= '0;
                perr_q   <= '0;
                drive_q  <= '0;
              end
              CMD_TICK: begin
                if (in_dt != '0) begin
                  state_q <= ST_DEN;
                end
              end
            endcase
          end
        end
        ST_DEN: begin
          if (op_done) begin
            den_q    <= prod[25:0];
            issued_q <= 1'b0;
            state_q  <= ST_NUM;
          end
        end
        ST_NUM: begin
          if (op_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_SPD;
          end
        end
        ST_SPD: begin
          if (op_done) begin
            issued_q   <= 1'b0;
            meas_q     <= meas_new;
            prev_cnt_q <= cnt_in_q;
            priority if (mode_q == MODE_HARD) begin
              drive_q <= '0;
              state_q <= ST_EMIT;
            end else if (mode_q == MODE_SOFT) begin
              se_q <= se_new;
              if ({1'b0, se_new} >= 18'(len_q)) begin
                mode_q  <= MODE_ACTIVE;
                goal_q  <= '0;
                state_q <= ST_ACC_MUL;
              end else begin
                state_q <= ST_STOP_MUL;
              end
            end else begin
              state_q <= ST_ACC_MUL;
            end
          end
        end
        ST_STOP_MUL: begin
          if (op_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_STOP_DIV;
          end
        end
        ST_STOP_DIV: begin
          if (op_done) begin
            issued_q <= 1'b0;
            goal_q   <= stop_goal;
            state_q  <= ST_ACC_MUL;
          end
        end
        ST_ACC_MUL: begin
          if (op_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_ACC_DIV;
          end
        end
        ST_ACC_DIV: begin
          if (op_done) begin
            issued_q <= 1'b0;
            maxd_q   <= quot[22:0];
            state_q  <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          ramped_q <= ramp_new;
          e_q      <= e_new;
          state_q  <= ST_EDT;
        end
        ST_EDT: begin
          if (op_done) begin
            issued_q <= 1'b0;
            cand_q   <= cand_sat;
            state_q  <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          if (op_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_DDIV;
          end
        end
        ST_DDIV: begin
          if (op_done) begin
            issued_q <= 1'b0;
            dterm_q  <= dterm_new;
            state_q  <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          if (op_done) begin
            issued_q <= 1'b0;
            pterm_q  <= term_new;
            state_q  <= ST_IMUL;
          end
        end
        ST_IMUL: begin
          if (op_done) begin
            issued_q <= 1'b0;
            if (in_range) begin
              isum_q  <= cand_q;
              o_q     <= o_new;
              state_q <= ST_CLMUL;
            end else begin
              state_q <= ST_IMUL2;
            end
          end
        end
        ST_IMUL2: begin
          if (op_done) begin
            issued_q <= 1'b0;
            o_q      <= o_new;
            state_q  <= ST_CLMUL;
          end
        end
        ST_CLMUL: begin
          if (cl_skip) begin
            cl_q    <= '0;
            state_q <= ST_FINAL;
          end else if (op_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_CLDIV;
          end
        end
        ST_CLDIV: begin
          if (op_done) begin
            issued_q <= 1'b0;
            cl_q     <= quot[9:0];
            state_q  <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          drive_q <= pwm2[10:0];
          perr_q  <= e_q;
          if (still) begin
            isum_q <= '0;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {5'b0, mode_q, goal_q, meas_q, drive_q, duty_rev, duty_fwd};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_IDLE) |-> (!mul_busy && !div_busy && !issued_q))
    else $error("arithmetic unit busy while idle");

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (12'(drive_q) <= LIM_POS) && (12'(drive_q) >= LIM_NEG))
    else $error("drive beyond duty limit");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result word raised outside emit");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for wheel_speed_pid_controller: bursty command stream in,
// stalled result stream out, each result word checked against a built-in predictor.
// Depends only on the controller RTL.
module tb_top;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_SOFT = 2'd2,
    CMD_HARD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_SOFT   = 2'd1,
    MODE_HARD   = 2'd2
  } mode_e;

  localparam logic [2:0] REG_PGAIN = 3'd0;
  localparam logic [2:0] REG_IGAIN = 3'd1;
  localparam logic [2:0] REG_DGAIN = 3'd2;
  localparam logic [2:0] REG_FLOOR = 3'd3;
  localparam logic [2:0] REG_CEIL  = 3'd4;
  localparam logic [2:0] REG_CPR   = 3'd5;
  localparam logic [2:0] REG_STOP  = 3'd6;
  localparam logic [2:0] REG_INV   = 3'd7;

  localparam longint SPD_MIN  = -65536;
  localparam longint SPD_MAX  = 65535;
  localparam longint TERM_LIM = 64'sd1 <<< 46;
  localparam longint SUM_MAX  = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN  = -(64'sd1 <<< 47);
  localparam int     LIMIT    = 3000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  ms;
    logic [31:0] enc;
    logic [16:0] tgt;
    logic [15:0] stop;
  } word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] goal;
    logic [16:0] spd;
    logic [10:0] drive;
    logic [9:0]  rev;
    logic [9:0]  fwd;
  } status_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_addr_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;

  wheel_speed_pid_controller dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  longint p_gain, i_gain, d_gain, floor_r, ceil_r, cpr_r, dstop_r, inv_r;
  longint mode_s, goal_s, ramp_s, meas_s, integ_s, perr_s, slen_s, sel_s, sstart_s, drv_s;
  logic [31:0] pcount_s;

  word_t   pending_q[$];
  status_t status_q[$];
  int      errors = 0;
  int      cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_term(longint g, longint x);
    longint m, ph, r;
    m = absv(x);
    ph = g * (m >>> 24);
    if (ph >= (64'sd1 <<< 30)) r = TERM_LIM;
    else r = (ph <<< 16) + ((g * (m & 64'hFFFFFF)) >>> 8);
    if (r > TERM_LIM) r = TERM_LIM;
    return x < 0 ? -r : r;
  endfunction

  function automatic void write_reg(logic [2:0] idx, longint v);
    case (idx)
      REG_PGAIN: p_gain = v & 64'hFFFFFF;
      REG_IGAIN: i_gain = v & 64'hFFFFFF;
      REG_DGAIN: d_gain = v & 64'hFFFFFF;
      REG_FLOOR: floor_r = longint'($signed(11'(v)));
      REG_CEIL:  ceil_r = longint'($signed(11'(v)));
      REG_CPR:   cpr_r = v & 64'hFFFF;
      REG_STOP:  dstop_r = v & 64'hFFFF;
      default:   inv_r = v & 1;
    endcase
  endfunction

  function automatic status_t report_status();
    status_t s;
    s.fwd = drv_s >= 0 ? 10'(drv_s) : '0;
    s.rev = drv_s < 0 ? 10'(-drv_s) : '0;
    s.drive = 11'(drv_s);
    s.spd = 17'(meas_s);
    s.goal = 17'(goal_s);
    s.mode = 2'(mode_s);
    return s;
  endfunction

  function automatic status_t control_step(word_t w);
    longint dt, d, cpr, maxd, dl, e, cand, diff, dm, dterm, pterm, lo, hi, o, pwm, top, cl;
    bit same;
    dt = w.ms;
    case (w.cmd)
      CMD_SET: begin
        d = longint'($signed(w.tgt));
        if (inv_r != 0) d = -d;
        goal_s = clip(d, SPD_MIN, SPD_MAX);
        if (mode_s == MODE_HARD) mode_s = MODE_ACTIVE;
        return report_status();
      end
      CMD_SOFT: begin
        if (mode_s == MODE_ACTIVE) begin
          integ_s = 0; perr_s = 0; mode_s = MODE_SOFT; sel_s = 0;
          slen_s = w.stop != 0 ? w.stop : dstop_r;
          sstart_s = goal_s;
        end
        return report_status();
      end
      CMD_HARD: begin
        mode_s = MODE_HARD;
        goal_s = 0; ramp_s = 0; integ_s = 0; perr_s = 0; drv_s = 0;
        return report_status();
      end
      default: ;
    endcase
    if (dt == 0) return report_status();
    d = longint'($signed(w.enc - pcount_s));
    cpr = cpr_r != 0 ? cpr_r : 1;
    meas_s = clip((d * 15360000) / (cpr * dt), SPD_MIN, SPD_MAX);
    pcount_s = w.enc;
    if (mode_s == MODE_HARD) begin
      drv_s = 0;
      return report_status();
    end
    if (mode_s == MODE_SOFT) begin
      sel_s = clip(sel_s + dt, 0, 131071);
      if (sel_s >= slen_s) begin
        mode_s = MODE_ACTIVE;
        goal_s = 0;
      end else goal_s = sstart_s - (sstart_s * sel_s) / slen_s;
    end
    maxd = (300 * 256 * dt) / 1000;
    dl = goal_s - ramp_s;
    same = (goal_s >= 0 && ramp_s >= 0) || (goal_s <= 0 && ramp_s <= 0);
    if (!(absv(goal_s) < absv(ramp_s) && same)) dl = clip(dl, -maxd, maxd);
    ramp_s += dl;
    e = ramp_s - meas_s;
    cand = clip(integ_s + e * dt, SUM_MIN, SUM_MAX);
    diff = e - perr_s;
    dm = (d_gain * absv(diff)) / (dt * 256);
    dterm = diff < 0 ? -dm : dm;
    pterm = scale_term(p_gain, e);
    lo = floor_r * 65536;
    hi = ceil_r * 65536;
    o = pterm + scale_term(i_gain, cand) + dterm;
    if (o >= lo && o <= hi) integ_s = cand;
    else o = pterm + scale_term(i_gain, integ_s) + dterm;
    if (o < lo) o = lo;
    else if (o > hi) o = hi;
    pwm = o < 0 ? -((-o) >>> 16) : (o >>> 16);
    pwm = clip(pwm, -1023, 1023);
    top = 150 * 256;
    cl = absv(meas_s) >= top ? 0 : (300 * (top - absv(meas_s))) / top;
    if (meas_s > 512 && pwm < -cl) pwm = -cl;
    else if (meas_s < -512 && pwm > cl) pwm = cl;
    if (ramp_s == 0 && absv(meas_s) < 512) begin
      pwm = 0;
      integ_s = 0;
    end
    drv_s = pwm;
    perr_s = e;
    return report_status();
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) status_q.push_back(control_step(word_t'(
        {s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[41:10], s_axis_tdata[58:42],
         s_axis_tdata[74:59]})));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          s_axis_tvalid <= 0;
          if (gap_left > 0) gap_left--;
        end else begin
          word_t w;
          w = pending_q.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser <= w.cmd;
          s_axis_tdata <= {5'b0, w.stop, w.tgt, w.enc, w.ms};
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else burst_left--;
        end
      end
    end
  end

  // monitor with its own stall pattern
  logic [15:0] stall_pat = 16'hA5F0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        status_t g, x;
        g = status_t'(m_axis_tdata[66:0]);
        if (status_q.size() == 0) report("unexpected word", 0, 0);
        else begin
          x = status_q.pop_front();
          if (g.fwd != x.fwd) report("duty_fwd", g.fwd, x.fwd);
          if (g.rev != x.rev) report("duty_rev", g.rev, x.rev);
          if (g.drive != x.drive) report("drive_value", $signed(g.drive), $signed(x.drive));
          if (g.spd != x.spd) report("speed_now", $signed(g.spd), $signed(x.spd));
          if (g.goal != x.goal) report("speed_goal", $signed(g.goal), $signed(x.goal));
          if (g.mode != x.mode) report("mode", g.mode, x.mode);
        end
      end
      stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13]};
      m_axis_tready <= (cycles / 3000) % 3 == 1 ? 1'b1 : (stall_pat[0] | stall_pat[3]);
    end
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic word_t mk(cmd_e c, longint ms, longint enc, longint tgt, longint stp);
    word_t w;
    w.cmd = c; w.ms = 10'(ms); w.enc = 32'(enc); w.tgt = 17'(tgt); w.stop = 16'(stp);
    return w;
  endfunction

  task automatic cfg(logic [2:0] idx, longint v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= 24'(v);
    write_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid && status_q.size() == 0);
    repeat (700) @(posedge clk_i);
  endtask

  // plausible run: enc moves by velocity*ms
  longint enc_pos = 0;
  task automatic add_run(int n, int vmax);
    int i, ms, r;
    longint v;
    v = $signed($urandom_range(0, 2 * vmax)) - vmax;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      ms = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(1, 20);
      if (r == 0) v = $signed($urandom_range(0, 2 * vmax)) - vmax;
      enc_pos += v * ms + $signed($urandom_range(0, 6)) - 3;
      if (r == 1) pending_q.push_back(mk(CMD_SET, $urandom, $urandom,
        $signed($urandom_range(0, 131071)) - 65536, $urandom));
      else if (r == 2) pending_q.push_back(mk(CMD_SET, $urandom, $urandom,
        $signed($urandom_range(0, 20000)) - 10000, $urandom));
      else if (r == 3) pending_q.push_back(mk(CMD_SOFT, $urandom, $urandom, $urandom,
        $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400)));
      else if (r == 4 && $urandom_range(0, 3) == 0)
        pending_q.push_back(mk(CMD_HARD, $urandom, $urandom, $urandom, $urandom));
      else if (r == 5 && $urandom_range(0, 3) == 0)
        pending_q.push_back(mk(CMD_TICK, ms, {$urandom}, $urandom, $urandom));
      else pending_q.push_back(mk(CMD_TICK, ms, enc_pos, $urandom, $urandom));
    end
  endtask

  initial begin
    int ph;
    p_gain = 65536; i_gain = 0; d_gain = 0; floor_r = -1023; ceil_r = 1023;
    cpr_r = 1920; dstop_r = 500; inv_r = 0;
    mode_s = MODE_ACTIVE; goal_s = 0; ramp_s = 0; meas_s = 0; integ_s = 0; perr_s = 0;
    pcount_s = '0; sstart_s = 0; slen_s = 0; sel_s = 0; drv_s = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0));
    pending_q.push_back(mk(CMD_SET, 1023, -1, 65535, 65535));
    pending_q.push_back(mk(CMD_TICK, 10, 500, 0, 0));
    pending_q.push_back(mk(CMD_TICK, 1023, 32'h7FFFFFFF, 0, 0));
    pending_q.push_back(mk(CMD_TICK, 1, 32'h80000000, 0, 0));
    pending_q.push_back(mk(CMD_TICK, 0, 5, -65536, 0));
    pending_q.push_back(mk(CMD_SOFT, 0, 0, 0, 0));
    pending_q.push_back(mk(CMD_SOFT, 0, 0, 0, 65535));
    pending_q.push_back(mk(CMD_TICK, 200, 32'h80000100, 0, 0));
    pending_q.push_back(mk(CMD_SET, 0, 0, -65536, 0));
    pending_q.push_back(mk(CMD_TICK, 400, 32'h80000100, 0, 0));
    pending_q.push_back(mk(CMD_HARD, 0, 0, 0, 0));
    pending_q.push_back(mk(CMD_TICK, 5, 32'h80001000, 0, 0));
    pending_q.push_back(mk(CMD_SOFT, 0, 0, 0, 7));
    pending_q.push_back(mk(CMD_SET, 0, 0, 3000, 0));
    pending_q.push_back(mk(CMD_SOFT, 0, 0, 0, 3));
    pending_q.push_back(mk(CMD_TICK, 1, 32'h80001000, 0, 0));
    pending_q.push_back(mk(CMD_TICK, 5, 32'h80001000, 0, 0));
    drain();
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cfg(REG_CPR, 0); cfg(REG_INV, 1); cfg(REG_STOP, 1); end
        1: begin cfg(REG_CPR, 65535); cfg(REG_PGAIN, 24'hFFFFFF); cfg(REG_IGAIN, 24'hFFFFFF);
          cfg(REG_DGAIN, 24'hFFFFFF); cfg(REG_STOP, 65535); end
        2: begin cfg(REG_CPR, 1920); cfg(REG_PGAIN, 40000); cfg(REG_IGAIN, 300);
          cfg(REG_DGAIN, 20000); cfg(REG_INV, 0); cfg(REG_STOP, 200); end
        3: begin cfg(REG_FLOOR, 1023); cfg(REG_CEIL, -1023); end
        4: begin cfg(REG_FLOOR, -200); cfg(REG_CEIL, 300); cfg(REG_IGAIN, 5000); end
        5: begin cfg(REG_PGAIN, 0); cfg(REG_IGAIN, 0); cfg(REG_DGAIN, 0);
          cfg(REG_FLOOR, -1023); cfg(REG_CEIL, 1023); cfg(REG_CPR, 1); end
        6: begin cfg(REG_CPR, 256); cfg(REG_PGAIN, 200000); cfg(REG_IGAIN, 2000);
          cfg(REG_DGAIN, 1000000); cfg(REG_FLOOR, 0); cfg(REG_CEIL, 1023); end
        default: begin cfg(REG_PGAIN, 65536); cfg(REG_IGAIN, 100); cfg(REG_DGAIN, 0);
          cfg(REG_FLOOR, -1023); cfg(REG_CEIL, 1023); cfg(REG_CPR, 1920); end
      endcase
      add_run(135, ph == 1 ? 40 : 3000);
      drain();
    end
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
